// ===== hw/rtl/pid_differential_steering_unit_defines.svh =====
// assertion macros shared by the steering unit rtl
// expects clk and arst_n in the scope of each use
`ifndef PID_DIFFERENTIAL_STEERING_UNIT_DEFINES_SVH
`define PID_DIFFERENTIAL_STEERING_UNIT_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define PDS_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define PDS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/pds_pkg.sv =====
// shared types, register codes and helpers of the steering unit
// no dependencies
package pds_pkg;

	localparam int POS_W   = 16;
	localparam int GAIN_W  = 16;
	localparam int SPEED_W = 16;
	localparam int LIMIT_W = 15;
	localparam int IDX_W   = 3;
	localparam int DATA_W  = 16;
	localparam int MAG_W   = 15;

	localparam logic [MAG_W-1:0]   MAG_MAX       = '1;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET   = '1;

	typedef enum logic [IDX_W-1:0] {
		REG_GAIN_P      = 3'd0,
		REG_GAIN_I      = 3'd1,
		REG_GAIN_D      = 3'd2,
		REG_BASE_SPEED  = 3'd3,
		REG_SPEED_LIMIT = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic signed [GAIN_W-1:0]  gain_p;
		logic signed [GAIN_W-1:0]  gain_i;
		logic signed [GAIN_W-1:0]  gain_d;
		logic signed [SPEED_W-1:0] base_wheel_speed;
		logic        [LIMIT_W-1:0] speed_limit;
	} cfg_regs_t;

	// clamp a 17 bit signed speed to +/- lim
	function automatic logic signed [SPEED_W-1:0] clamp_speed(
		input logic signed [SPEED_W:0] v,
		input logic [LIMIT_W-1:0] lim
	);
		logic signed [SPEED_W:0] hi;
		logic signed [SPEED_W:0] lo;
		logic signed [SPEED_W:0] r;
		hi = {2'b00, lim};
		lo = -hi;
		if (v > hi) begin
			r = hi;
		end else if (v < lo) begin
			r = lo;
		end else begin
			r = v;
		end
		return r[SPEED_W-1:0];
	endfunction

endpackage

// ===== hw/rtl/pds_sensor_if.sv =====
// input channel of the steering unit: one line position per item
// depends on pds_pkg
interface pds_sensor_if;
	import pds_pkg::*;

	logic                    valid;
	logic                    ready;
	logic signed [POS_W-1:0] position;

	modport source (output valid, output position, input ready);
	modport sink (input valid, input position, output ready);
endinterface

// ===== hw/rtl/pds_drive_if.sv =====
// output channel of the steering unit: both wheel speeds per item
// depends on pds_pkg
interface pds_drive_if;
	import pds_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [SPEED_W-1:0] left_drive;
	logic signed [SPEED_W-1:0] right_drive;

	modport source (output valid, output left_drive, output right_drive, input ready);
	modport sink (input valid, input left_drive, input right_drive, output ready);
endinterface

// ===== hw/rtl/pds_cfg_if.sv =====
// register write channel of the steering unit
// depends on pds_pkg
interface pds_cfg_if;
	import pds_pkg::*;

	logic              valid;
	logic              ready;
	logic [IDX_W-1:0]  index;
	logic [DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/pds_front.sv =====
// error stage: derivative difference and clamped integral, first pipeline register
// depends on pds_pkg and the assertion macro header
`include "pid_differential_steering_unit_defines.svh"

module pds_front #(
	parameter int INTEGRAL_LIMIT = 1000,
	parameter int SUM_W          = 11
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [pds_pkg::POS_W-1:0]  position,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [pds_pkg::POS_W-1:0]  err_out,
	output logic signed [pds_pkg::POS_W:0]    diff_out,
	output logic signed [SUM_W-1:0]           sum_out
);
	import pds_pkg::*;

	localparam int ACC_W = ((SUM_W > POS_W) ? SUM_W : POS_W) + 1;
	localparam logic signed [ACC_W-1:0] LIM_P = ACC_W'(INTEGRAL_LIMIT);
	localparam logic signed [ACC_W-1:0] LIM_N = -LIM_P;

	logic signed [POS_W-1:0] prev_q;
	logic signed [SUM_W-1:0] sum_q;
	logic                    valid_s1;
	logic signed [POS_W-1:0] err_s1;
	logic signed [POS_W:0]   diff_s1;
	logic signed [SUM_W-1:0] sum_s1;

	logic                    take;
	logic signed [ACC_W-1:0] acc;
	logic signed [ACC_W-1:0] acc_clamped;
	logic signed [POS_W:0]   diff;

	assign in_ready = !valid_s1 || out_ready;
	assign take     = in_valid && in_ready;

	always_comb begin
		acc  = {{(ACC_W-SUM_W){sum_q[SUM_W-1]}}, sum_q}
		     + {{(ACC_W-POS_W){position[POS_W-1]}}, position};
		diff = {position[POS_W-1], position} - {prev_q[POS_W-1], prev_q};
		if (acc > LIM_P) begin
			acc_clamped = LIM_P;
		end else if (acc < LIM_N) begin
			acc_clamped = LIM_N;
		end else begin
			acc_clamped = acc;
		end
	end

	// running state moves on every accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q   <= '0;
			sum_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (take) begin
				prev_q <= position;
				sum_q  <= acc_clamped[SUM_W-1:0];
			end
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			err_s1  <= position;
			diff_s1 <= diff;
			sum_s1  <= acc_clamped[SUM_W-1:0];
		end
	end

	assign out_valid = valid_s1;
	assign err_out   = err_s1;
	assign diff_out  = diff_s1;
	assign sum_out   = sum_s1;

	logic signed [ACC_W-1:0] sum_ext;
	assign sum_ext = {{(ACC_W-SUM_W){sum_q[SUM_W-1]}}, sum_q};

	`PDS_ASSERT_IMP(a_sum_in_range, 1'b1, (sum_ext <= LIM_P) && (sum_ext >= LIM_N), "integral out of range")
	`PDS_ASSERT_NEXT(a_prev_follows, take, prev_q == $past(position), "previous error not updated")
	`PDS_ASSERT_NEXT(a_state_holds, !take, $stable(prev_q) && $stable(sum_q), "state moved without an item")

endmodule

// ===== hw/rtl/pds_corr.sv =====
// correction stages: three gain products, then their exact sum
// depends on pds_pkg
module pds_corr #(
	parameter int SUM_W = 11,
	parameter int CW    = 35
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  pds_pkg::cfg_regs_t                cfg,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [pds_pkg::POS_W-1:0]  err_in,
	input  logic signed [pds_pkg::POS_W:0]    diff_in,
	input  logic signed [SUM_W-1:0]           sum_in,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [CW-1:0]              corr_out
);
	import pds_pkg::*;

	localparam int PP_W = GAIN_W + POS_W;
	localparam int PI_W = GAIN_W + SUM_W;
	localparam int PD_W = GAIN_W + POS_W + 1;

	logic                   valid_s2;
	logic                   valid_s3;
	logic signed [PP_W-1:0] prod_p_s2;
	logic signed [PI_W-1:0] prod_i_s2;
	logic signed [PD_W-1:0] prod_d_s2;
	logic signed [CW-1:0]   corr_s3;

	logic signed [PP_W-1:0] prod_p;
	logic signed [PI_W-1:0] prod_i;
	logic signed [PD_W-1:0] prod_d;
	logic signed [CW-1:0]   corr;
	logic                   open_s3;

	assign open_s3  = !valid_s3 || out_ready;
	assign in_ready = !valid_s2 || open_s3;

	always_comb begin
		prod_p = $signed(cfg.gain_p) * err_in;
		prod_i = $signed(cfg.gain_i) * sum_in;
		prod_d = $signed(cfg.gain_d) * diff_in;
		corr   = {{(CW-PP_W){prod_p_s2[PP_W-1]}}, prod_p_s2}
		       + {{(CW-PI_W){prod_i_s2[PI_W-1]}}, prod_i_s2}
		       + {{(CW-PD_W){prod_d_s2[PD_W-1]}}, prod_d_s2};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s2 <= in_valid;
			end
			if (open_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			prod_p_s2 <= prod_p;
			prod_i_s2 <= prod_i;
			prod_d_s2 <= prod_d;
		end
		if (valid_s2 && open_s3) begin
			corr_s3 <= corr;
		end
	end

	assign out_valid = valid_s3;
	assign corr_out  = corr_s3;

endmodule

// ===== hw/rtl/pds_mix.sv =====
// mixing stages: correction magnitude, then wheel speeds and limit clamp
// depends on pds_pkg and the assertion macro header
`include "pid_differential_steering_unit_defines.svh"

module pds_mix #(
	parameter int GAIN_FRAC_BITS = 8,
	parameter int CW             = 35
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  pds_pkg::cfg_regs_t                  cfg,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [CW-1:0]                corr_in,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [pds_pkg::SPEED_W-1:0]  left_drive,
	output logic signed [pds_pkg::SPEED_W-1:0]  right_drive
);
	import pds_pkg::*;

	logic                      valid_s4;
	logic [MAG_W-1:0]          mag_s4;
	logic                      left_s4;
	logic                      valid_q;
	logic signed [SPEED_W-1:0] left_q;
	logic signed [SPEED_W-1:0] right_q;

	logic [CW-1:0]             mag_full;
	logic [CW-1:0]             mag_shift;
	logic [MAG_W-1:0]          mag_sat;
	logic                      corr_pos;
	logic signed [SPEED_W:0]   base_ext;
	logic signed [SPEED_W:0]   slowed;
	logic signed [SPEED_W-1:0] left_n;
	logic signed [SPEED_W-1:0] right_n;
	logic                      open_q;

	assign open_q   = !valid_q || out_ready;
	assign in_ready = !valid_s4 || open_q;

	always_comb begin
		mag_full  = corr_in[CW-1] ? CW'(-corr_in) : CW'(corr_in);
		mag_shift = mag_full >> GAIN_FRAC_BITS;
		mag_sat   = (|mag_shift[CW-1:MAG_W]) ? MAG_MAX : mag_shift[MAG_W-1:0];
		corr_pos  = !corr_in[CW-1] && (|corr_in);

		base_ext = {cfg.base_wheel_speed[SPEED_W-1], cfg.base_wheel_speed};
		slowed   = base_ext - {2'b00, mag_s4};
		left_n   = clamp_speed(left_s4 ? slowed : base_ext, cfg.speed_limit);
		right_n  = clamp_speed(left_s4 ? base_ext : slowed, cfg.speed_limit);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s4 <= in_valid;
			end
			if (open_q) begin
				valid_q <= valid_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mag_s4  <= mag_sat;
			left_s4 <= corr_pos;
		end
		if (valid_s4 && open_q) begin
			left_q  <= left_n;
			right_q <= right_n;
		end
	end

	assign out_valid   = valid_q;
	assign left_drive  = left_q;
	assign right_drive = right_q;

	logic signed [SPEED_W:0]   lim_ext;
	logic signed [SPEED_W:0]   left_ext;
	logic signed [SPEED_W:0]   right_ext;
	logic signed [SPEED_W-1:0] base_lim;
	assign lim_ext   = {2'b00, cfg.speed_limit};
	assign left_ext  = {left_q[SPEED_W-1], left_q};
	assign right_ext = {right_q[SPEED_W-1], right_q};
	assign base_lim  = clamp_speed(base_ext, cfg.speed_limit);

	`PDS_ASSERT_IMP(a_left_limit, valid_q, (left_ext <= lim_ext) && (left_ext >= -lim_ext), "left speed beyond limit")
	`PDS_ASSERT_IMP(a_right_limit, valid_q, (right_ext <= lim_ext) && (right_ext >= -lim_ext), "right speed beyond limit")
	`PDS_ASSERT_IMP(a_one_wheel_slowed, valid_q, (left_q == base_lim) || (right_q == base_lim), "both wheels corrected")

endmodule

// ===== hw/rtl/pid_differential_steering_unit.sv =====
// each result passes stages 1 to 4 and the output register before it is offered
// throughput: one item per cycle while drive.ready is high; five register stages
//   each advance alone: bubbles close up; a held result lets earlier stages fill
// reset (arst_n low, asynchronous): pipeline emptied, previous error and integral
//   cleared, gains and base speed 0, speed limit 32767
// depends on pds_pkg, the channel interfaces, pds_front, pds_corr and pds_mix
module pid_differential_steering_unit #(
	parameter int GAIN_FRAC_BITS = 8,
	parameter int INTEGRAL_LIMIT = 1000
) (
	input  logic      clk,
	input  logic      arst_n,
	pds_cfg_if.sink   cfg,
	pds_sensor_if.sink sensor,
	pds_drive_if.source drive
);
	import pds_pkg::*;

	// integral width: enough for +/- INTEGRAL_LIMIT in two's complement
	localparam int SUM_W = $clog2(INTEGRAL_LIMIT + 1) + 1;
	// correction width: widest product plus two bits of growth for the three-way sum
	localparam int PI_W  = GAIN_W + SUM_W;
	localparam int PD_W  = GAIN_W + POS_W + 1;
	localparam int CW    = ((PI_W > PD_W) ? PI_W : PD_W) + 2;

	// configuration registers: the user writes them only while the pipeline is empty;
	// the block does not enforce this, and later stages read them live
	cfg_regs_t regs_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.gain_p           <= '0;
			regs_q.gain_i           <= '0;
			regs_q.gain_d           <= '0;
			regs_q.base_wheel_speed <= '0;
			regs_q.speed_limit      <= LIMIT_RESET;
		end else if (cfg.valid) begin
			unique case (cfg_reg_t'(cfg.index))
				REG_GAIN_P:      regs_q.gain_p           <= cfg.data;
				REG_GAIN_I:      regs_q.gain_i           <= cfg.data;
				REG_GAIN_D:      regs_q.gain_d           <= cfg.data;
				REG_BASE_SPEED:  regs_q.base_wheel_speed <= cfg.data;
				REG_SPEED_LIMIT: regs_q.speed_limit      <= cfg.data[LIMIT_W-1:0];
				default: begin
					// unused register index, write dropped
				end
			endcase
		end
	end

	// stage 1: error difference and clamped integral
	logic                    front_valid;
	logic                    front_ready;
	logic signed [POS_W-1:0] front_err;
	logic signed [POS_W:0]   front_diff;
	logic signed [SUM_W-1:0] front_sum;

	pds_front #(
		.INTEGRAL_LIMIT (INTEGRAL_LIMIT),
		.SUM_W          (SUM_W)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sensor.valid),
		.in_ready  (sensor.ready),
		.position  (sensor.position),
		.out_valid (front_valid),
		.out_ready (front_ready),
		.err_out   (front_err),
		.diff_out  (front_diff),
		.sum_out   (front_sum)
	);

	// stages 2 and 3: gain products, then the exact correction
	logic                 corr_valid;
	logic                 corr_ready;
	logic signed [CW-1:0] corr;

	pds_corr #(
		.SUM_W (SUM_W),
		.CW    (CW)
	) u_corr (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (regs_q),
		.in_valid  (front_valid),
		.in_ready  (front_ready),
		.err_in    (front_err),
		.diff_in   (front_diff),
		.sum_in    (front_sum),
		.out_valid (corr_valid),
		.out_ready (corr_ready),
		.corr_out  (corr)
	);

	// stage 4 and output register: magnitude with saturation, wheel select, limit clamp
	pds_mix #(
		.GAIN_FRAC_BITS (GAIN_FRAC_BITS),
		.CW             (CW)
	) u_mix (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (regs_q),
		.in_valid    (corr_valid),
		.in_ready    (corr_ready),
		.corr_in     (corr),
		.out_valid   (drive.valid),
		.out_ready   (drive.ready),
		.left_drive  (drive.left_drive),
		.right_drive (drive.right_drive)
	);

endmodule
